>>> rtl/core/atom_pair_clash_counter_top_defines.svh
// Assertion helpers shared by the clash counter RTL.
`ifndef ATOM_PAIR_CLASH_COUNTER_TOP_DEFINES_SVH
`define ATOM_PAIR_CLASH_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apcc assertion failed");

// Next-cycle implication, disabled during reset.
`define APCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apcc assertion failed");

`endif

>>> rtl/core/apcc_pkg.sv
package apcc_pkg;

    localparam int DEF_COORD_WIDTH  = 20;
    localparam int DEF_RADIUS_WIDTH = 10;
    localparam int DEF_COUNT_WIDTH  = 32;

    localparam int CHAR_WIDTH        = 8;
    localparam int BOND_WIDTH        = 8;
    localparam int CLASH_TOTAL_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH   = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CARBON   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OXYGEN   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NITROGEN = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HYDROGEN = 2'd3;

    // element codes; a known code equals its radius row index
    localparam logic [2:0] ELEM_C       = 3'd0;
    localparam logic [2:0] ELEM_O       = 3'd1;
    localparam logic [2:0] ELEM_N       = 3'd2;
    localparam logic [2:0] ELEM_H       = 3'd3;
    localparam logic [2:0] ELEM_UNKNOWN = 3'd4;

    localparam logic [CHAR_WIDTH-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_WIDTH-1:0] CHAR_O = 8'h4F;
    localparam logic [CHAR_WIDTH-1:0] CHAR_N = 8'h4E;
    localparam logic [CHAR_WIDTH-1:0] CHAR_H = 8'h48;

    // pairs this close in the bond graph are never checked
    localparam logic [BOND_WIDTH-1:0] BOND_LIMIT = 8'd3;

    // reset limits, angstrom * 256 rounded
    localparam int LIMIT_CC = 768;
    localparam int LIMIT_CO = 691;
    localparam int LIMIT_CN = 717;
    localparam int LIMIT_CH = 563;
    localparam int LIMIT_OO = 691;
    localparam int LIMIT_ON = 666;
    localparam int LIMIT_OH = 563;
    localparam int LIMIT_NN = 666;
    localparam int LIMIT_NH = 563;
    localparam int LIMIT_HH = 486;

    function automatic logic [2:0] elem_code(input logic [CHAR_WIDTH-1:0] ch);
        logic [2:0] code;
        case (ch)
            CHAR_C:  code = ELEM_C;
            CHAR_O:  code = ELEM_O;
            CHAR_N:  code = ELEM_N;
            CHAR_H:  code = ELEM_H;
            default: code = ELEM_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/apcc_if.sv
interface apcc_pair_if #(
    parameter int COORD_WIDTH = apcc_pkg::DEF_COORD_WIDTH
);
    logic                                    valid;
    logic                                    ready;
    logic        [apcc_pkg::CHAR_WIDTH-1:0]  first_element_char;
    logic        [apcc_pkg::CHAR_WIDTH-1:0]  second_element_char;
    logic signed [COORD_WIDTH-1:0]           first_x;
    logic signed [COORD_WIDTH-1:0]           first_y;
    logic signed [COORD_WIDTH-1:0]           first_z;
    logic signed [COORD_WIDTH-1:0]           second_x;
    logic signed [COORD_WIDTH-1:0]           second_y;
    logic signed [COORD_WIDTH-1:0]           second_z;
    logic        [apcc_pkg::BOND_WIDTH-1:0]  bond_separation;
    logic                                    start_of_structure;
    logic                                    last_pair;

    modport source (
        output valid, first_element_char, second_element_char,
               first_x, first_y, first_z, second_x, second_y, second_z,
               bond_separation, start_of_structure, last_pair,
        input  ready
    );

    modport sink (
        input  valid, first_element_char, second_element_char,
               first_x, first_y, first_z, second_x, second_y, second_z,
               bond_separation, start_of_structure, last_pair,
        output ready
    );
endinterface

interface apcc_result_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       is_clash;
    logic [apcc_pkg::CLASH_TOTAL_WIDTH-1:0]     clash_total;
    logic                                       unknown_element;
    logic                                       final_result;

    modport source (
        output valid, is_clash, clash_total, unknown_element, final_result,
        input  ready
    );

    modport sink (
        input  valid, is_clash, clash_total, unknown_element, final_result,
        output ready
    );
endinterface

>>> rtl/core/atom_pair_clash_counter_top.sv
// Hard-sphere clash counter. One atom pair word enters per cycle while ready is high, and
// its result word leaves from the result register: the pair lands in an input register, and
// the distance check, limit lookup and running-count update sit in one stage ahead of the
// result register. Sustained rate is one pair per clock while results are accepted, set by
// that single stage, which also closes the count loop. Ready stays high while the input
// register is empty or the result register is free or being drained, so a waiting result
// stalls new pairs only once the input register holds a pair as well. Radius registers may
// be written only while no pair is in flight; index 0..3 selects the carbon, oxygen,
// nitrogen and hydrogen rows, with limits packed lowest field first.
`include "atom_pair_clash_counter_top_defines.svh"

module atom_pair_clash_counter_top #(
    parameter int COORD_WIDTH  = apcc_pkg::DEF_COORD_WIDTH,
    parameter int RADIUS_WIDTH = apcc_pkg::DEF_RADIUS_WIDTH,
    parameter int COUNT_WIDTH  = apcc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [apcc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [4*RADIUS_WIDTH-1:0]               cfg_data,
    apcc_pair_if.sink                               pairs,
    apcc_result_if.source                           results
);

    localparam int R      = RADIUS_WIDTH;
    localparam int MAG_W  = (COORD_WIDTH >= RADIUS_WIDTH) ? COORD_WIDTH + 1 : RADIUS_WIDTH + 1;
    localparam int SUM_W  = 2 * RADIUS_WIDTH + 2;
    localparam int TOT_W  = apcc_pkg::CLASH_TOTAL_WIDTH;

    localparam logic [4*R-1:0] CARBON_RESET = {R'(apcc_pkg::LIMIT_CH), R'(apcc_pkg::LIMIT_CN),
                                               R'(apcc_pkg::LIMIT_CO), R'(apcc_pkg::LIMIT_CC)};
    localparam logic [3*R-1:0] OXYGEN_RESET = {R'(apcc_pkg::LIMIT_OH), R'(apcc_pkg::LIMIT_ON),
                                               R'(apcc_pkg::LIMIT_OO)};
    localparam logic [2*R-1:0] NITROGEN_RESET = {R'(apcc_pkg::LIMIT_NH), R'(apcc_pkg::LIMIT_NN)};
    localparam logic [R-1:0]   HYDROGEN_RESET = R'(apcc_pkg::LIMIT_HH);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // radius registers
    logic [4*R-1:0] carbon_reg;
    logic [3*R-1:0] oxygen_reg;
    logic [2*R-1:0] nitrogen_reg;
    logic [R-1:0]   hydrogen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carbon_reg   <= CARBON_RESET;
            oxygen_reg   <= OXYGEN_RESET;
            nitrogen_reg <= NITROGEN_RESET;
            hydrogen_reg <= HYDROGEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                apcc_pkg::REG_CARBON:   carbon_reg   <= cfg_data;
                apcc_pkg::REG_OXYGEN:   oxygen_reg   <= cfg_data[3*R-1:0];
                apcc_pkg::REG_NITROGEN: nitrogen_reg <= cfg_data[2*R-1:0];
                apcc_pkg::REG_HYDROGEN: hydrogen_reg <= cfg_data[R-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic                                 s1_valid_reg;
    logic [apcc_pkg::CHAR_WIDTH-1:0]      s1_char_a_reg;
    logic [apcc_pkg::CHAR_WIDTH-1:0]      s1_char_b_reg;
    logic signed [COORD_WIDTH-1:0]        s1_first_reg [3];
    logic signed [COORD_WIDTH-1:0]        s1_second_reg [3];
    logic [apcc_pkg::BOND_WIDTH-1:0]      s1_bond_reg;
    logic                                 s1_start_reg;
    logic                                 s1_last_reg;

    // result register
    logic                      s2_valid_reg;
    logic                      s2_clash_reg;
    logic [TOT_W-1:0]          s2_total_reg;
    logic                      s2_unknown_reg;
    logic                      s2_final_reg;

    logic [COUNT_WIDTH-1:0]    count_reg;
    logic [COUNT_WIDTH-1:0]    count_next;

    logic s2_free;
    logic s1_adv;
    logic in_take;

    assign s2_free = !s2_valid_reg || results.ready;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign in_take = pairs.valid && pairs.ready;
    assign pairs.ready = !s1_valid_reg || s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pairs.ready)
        begin
            s1_valid_reg <= pairs.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_a_reg    <= pairs.first_element_char;
            s1_char_b_reg    <= pairs.second_element_char;
            s1_first_reg[0]  <= pairs.first_x;
            s1_first_reg[1]  <= pairs.first_y;
            s1_first_reg[2]  <= pairs.first_z;
            s1_second_reg[0] <= pairs.second_x;
            s1_second_reg[1] <= pairs.second_y;
            s1_second_reg[2] <= pairs.second_z;
            s1_bond_reg      <= pairs.bond_separation;
            s1_start_reg     <= pairs.start_of_structure;
            s1_last_reg      <= pairs.last_pair;
        end
    end

    // element lookup and limit selection
    logic [2:0]     code_a;
    logic [2:0]     code_b;
    logic           unknown_c;
    logic [1:0]     row_lo;
    logic [1:0]     row_hi;
    logic [1:0]     span;
    logic [4*R-1:0] row_bits;
    logic [R-1:0]   limit;

    always_comb
    begin
        code_a    = apcc_pkg::elem_code(s1_char_a_reg);
        code_b    = apcc_pkg::elem_code(s1_char_b_reg);
        unknown_c = (code_a == apcc_pkg::ELEM_UNKNOWN) || (code_b == apcc_pkg::ELEM_UNKNOWN);
        if (code_a[1:0] <= code_b[1:0])
        begin
            row_lo = code_a[1:0];
            row_hi = code_b[1:0];
        end
        else
        begin
            row_lo = code_b[1:0];
            row_hi = code_a[1:0];
        end
        span = row_hi - row_lo;
        case (row_lo)
            apcc_pkg::REG_CARBON:   row_bits = carbon_reg;
            apcc_pkg::REG_OXYGEN:   row_bits = {{R{1'b0}}, oxygen_reg};
            apcc_pkg::REG_NITROGEN: row_bits = {{(2*R){1'b0}}, nitrogen_reg};
            apcc_pkg::REG_HYDROGEN: row_bits = {{(3*R){1'b0}}, hydrogen_reg};
            default:                row_bits = carbon_reg;
        endcase
        limit = row_bits[span*R +: R];
    end

    // squared distance against squared limit
    logic signed [COORD_WIDTH:0] diff [3];
    logic [MAG_W-1:0]            mag [3];
    logic [2*R-1:0]              sq [3];
    logic                        far_c;
    logic [SUM_W-1:0]            dist_sq;
    logic [2*R-1:0]              limit_sq;
    logic                        clash_c;

    always_comb
    begin
        far_c = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {s1_first_reg[i][COORD_WIDTH-1], s1_first_reg[i]}
                    - {s1_second_reg[i][COORD_WIDTH-1], s1_second_reg[i]};
            mag[i]  = MAG_W'(diff[i][COORD_WIDTH] ? $unsigned(-diff[i]) : $unsigned(diff[i]));
            far_c   = far_c || (|mag[i][MAG_W-1:R]);
            sq[i]   = mag[i][R-1:0] * mag[i][R-1:0];
        end
        dist_sq  = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
        limit_sq = limit * limit;
        clash_c  = !unknown_c && (s1_bond_reg > apcc_pkg::BOND_LIMIT) && !far_c
                && (dist_sq < SUM_W'(limit_sq));
    end

    // running count, cleared at a structure's first pair
    logic [COUNT_WIDTH-1:0]       count_base;
    logic [COUNT_WIDTH+TOT_W-1:0] count_wide;

    always_comb
    begin
        count_base = s1_start_reg ? '0 : count_reg;
        count_next = (clash_c && (count_base != COUNT_MAX)) ? count_base + 1'b1 : count_base;
        count_wide = {{TOT_W{1'b0}}, count_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                count_reg <= count_next;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_clash_reg   <= clash_c;
            s2_total_reg   <= count_wide[TOT_W-1:0];
            s2_unknown_reg <= unknown_c;
            s2_final_reg   <= s1_last_reg;
        end
    end

    assign results.valid           = s2_valid_reg;
    assign results.is_clash        = s2_clash_reg;
    assign results.clash_total     = s2_total_reg;
    assign results.unknown_element = s2_unknown_reg;
    assign results.final_result    = s2_final_reg;

    `APCC_ASSERT_IMP(a_unknown_never_clash, clk, rst_n,
                     s2_valid_reg && s2_unknown_reg, !s2_clash_reg)
    `APCC_ASSERT_IMP(a_near_bonds_no_clash, clk, rst_n,
                     s1_valid_reg && (s1_bond_reg <= apcc_pkg::BOND_LIMIT), !clash_c)
    `APCC_ASSERT_NEXT(a_count_holds_when_idle, clk, rst_n, !s1_adv, $stable(count_reg))

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apcc_pkg::*;

    localparam int CW              = DEF_COORD_WIDTH;
    localparam int RW              = DEF_RADIUS_WIDTH;
    localparam int DATA_W          = 4 * RW;
    localparam int PAIRS_PER_PHASE = 90;
    localparam int PRESSURE_CYCLES = 120;

    // C, O, N, H in row order, one byte each
    localparam logic [4*CHAR_WIDTH-1:0] ROW_CHARS = {CHAR_H, CHAR_N, CHAR_O, CHAR_C};

    typedef struct {
        logic        [CHAR_WIDTH-1:0] first_char;
        logic        [CHAR_WIDTH-1:0] second_char;
        logic signed [CW-1:0]         first_x;
        logic signed [CW-1:0]         first_y;
        logic signed [CW-1:0]         first_z;
        logic signed [CW-1:0]         second_x;
        logic signed [CW-1:0]         second_y;
        logic signed [CW-1:0]         second_z;
        logic        [BOND_WIDTH-1:0] bonds;
        logic                         start;
        logic                         last;
    } pair_word_t;

    typedef struct {
        logic                         is_clash;
        logic [CLASH_TOTAL_WIDTH-1:0] clash_total;
        logic                         unknown_element;
        logic                         final_result;
    } verdict_t;

    class clash_count_model;
        logic [DATA_W-1:0]            radius_rows [4];
        logic [DEF_COUNT_WIDTH-1:0]   clash_count;
        verdict_t                     pending_verdicts [$];
        int                           failures;

        function new();
            radius_rows[REG_CARBON]   = {RW'(LIMIT_CH), RW'(LIMIT_CN), RW'(LIMIT_CO),
                                         RW'(LIMIT_CC)};
            radius_rows[REG_OXYGEN]   = DATA_W'({RW'(LIMIT_OH), RW'(LIMIT_ON), RW'(LIMIT_OO)});
            radius_rows[REG_NITROGEN] = DATA_W'({RW'(LIMIT_NH), RW'(LIMIT_NN)});
            radius_rows[REG_HYDROGEN] = DATA_W'(LIMIT_HH);
            clash_count = '0;
            failures    = 0;
        endfunction

        function void write_radius(logic [CFG_INDEX_WIDTH-1:0] idx, logic [DATA_W-1:0] data);
            // each row is one field narrower than the one before it
            radius_rows[idx] = data & ({DATA_W{1'b1}} >> (RW * int'(idx)));
        endfunction

        function logic [2:0] row_of(logic [CHAR_WIDTH-1:0] ch);
            logic [2:0] row;
            case (ch)
                CHAR_C:  row = ELEM_C;
                CHAR_O:  row = ELEM_O;
                CHAR_N:  row = ELEM_N;
                CHAR_H:  row = ELEM_H;
                default: row = ELEM_UNKNOWN;
            endcase
            return row;
        endfunction

        function logic [RW-1:0] limit_of(logic [2:0] a, logic [2:0] b);
            logic [2:0] lo;
            logic [2:0] hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            return RW'(radius_rows[lo[1:0]] >> (RW * int'(hi - lo)));
        endfunction

        function void note_pair(pair_word_t p);
            logic [2:0]    ea;
            logic [2:0]    eb;
            logic [RW-1:0] lim;
            int            d [3];
            longint        span2;
            bit            far;
            verdict_t      v;
            ea = row_of(p.first_char);
            eb = row_of(p.second_char);
            v.unknown_element = (ea == ELEM_UNKNOWN) || (eb == ELEM_UNKNOWN);
            v.is_clash = 1'b0;
            if (p.start)
                clash_count = '0;
            if (!v.unknown_element && p.bonds > BOND_LIMIT)
            begin
                d[0] = int'(p.first_x) - int'(p.second_x);
                d[1] = int'(p.first_y) - int'(p.second_y);
                d[2] = int'(p.first_z) - int'(p.second_z);
                far   = 1'b0;
                span2 = 0;
                foreach (d[k])
                begin
                    if (d[k] >= (1 << RW) || d[k] <= -(1 << RW))
                        far = 1'b1;
                    span2 += longint'(d[k]) * d[k];
                end
                lim = limit_of(ea, eb);
                if (!far)
                    v.is_clash = span2 < longint'(lim) * longint'(lim);
            end
            if (v.is_clash && clash_count != '1)
                clash_count++;
            v.clash_total  = CLASH_TOTAL_WIDTH'(clash_count);
            v.final_result = p.last;
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("result word with nothing expected");
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.is_clash !== want.is_clash)
            begin
                $error("is_clash expected %0d actual %0d", want.is_clash, got.is_clash);
                failures++;
            end
            if (got.clash_total !== want.clash_total)
            begin
                $error("clash_total expected %0d actual %0d", want.clash_total,
                       got.clash_total);
                failures++;
            end
            if (got.unknown_element !== want.unknown_element)
            begin
                $error("unknown_element expected %0d actual %0d", want.unknown_element,
                       got.unknown_element);
                failures++;
            end
            if (got.final_result !== want.final_result)
            begin
                $error("final_result expected %0d actual %0d", want.final_result,
                       got.final_result);
                failures++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_CARBON;
    logic [DATA_W-1:0]          cfg_data = '0;

    int send_idle_pct = 38;
    int recv_idle_pct = 67;
    bit hold_request  = 1'b0;

    clash_count_model board = new();

    apcc_pair_if #(.COORD_WIDTH(CW)) pair_ch();
    apcc_result_if                   result_ch();

    atom_pair_clash_counter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pairs     (pair_ch),
        .results   (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic drive_pair(input pair_word_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pair_ch.valid               <= 1'b1;
        pair_ch.first_element_char  <= p.first_char;
        pair_ch.second_element_char <= p.second_char;
        pair_ch.first_x             <= p.first_x;
        pair_ch.first_y             <= p.first_y;
        pair_ch.first_z             <= p.first_z;
        pair_ch.second_x            <= p.second_x;
        pair_ch.second_y            <= p.second_y;
        pair_ch.second_z            <= p.second_z;
        pair_ch.bond_separation     <= p.bonds;
        pair_ch.start_of_structure  <= p.start;
        pair_ch.last_pair           <= p.last;
        @(posedge clk);
        while (pair_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_pair(p);
    endtask

    task automatic write_radius(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_radius(idx, data);
    endtask

    task automatic wait_drained();
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        // two-stage pipe, plus margin
        repeat (4) @(posedge clk);
    endtask

    function automatic pair_word_t pair_at(logic [CHAR_WIDTH-1:0] ca,
                                           logic [CHAR_WIDTH-1:0] cb, int dx,
                                           logic [BOND_WIDTH-1:0] bonds, bit start, bit last);
        pair_word_t p;
        p.first_char  = ca;
        p.second_char = cb;
        p.first_x     = CW'(dx);
        p.first_y     = '0;
        p.first_z     = '0;
        p.second_x    = '0;
        p.second_y    = '0;
        p.second_z    = '0;
        p.bonds       = bonds;
        p.start       = start;
        p.last        = last;
        return p;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] pick_char();
        if ($urandom_range(99) < 92)
            return ROW_CHARS[CHAR_WIDTH * $urandom_range(3) +: CHAR_WIDTH];
        return CHAR_WIDTH'($urandom_range(255));
    endfunction

    function automatic pair_word_t random_pair(bit start, bit last);
        pair_word_t         p;
        logic signed [CW-1:0] a [3];
        logic signed [CW-1:0] b [3];
        int                 spread;
        int                 r;
        r = $urandom_range(99);
        spread = (r < 60) ? 500 : (r < 85) ? 1100 : 0;
        foreach (a[k])
        begin
            a[k] = CW'($urandom());
            if (spread == 0)
                b[k] = CW'($urandom());
            else
                b[k] = a[k] + CW'(int'($urandom_range(2 * spread)) - spread);
        end
        p.first_char  = pick_char();
        p.second_char = pick_char();
        p.first_x     = a[0];
        p.first_y     = a[1];
        p.first_z     = a[2];
        p.second_x    = b[0];
        p.second_y    = b[1];
        p.second_z    = b[2];
        p.bonds       = ($urandom_range(99) < 70) ? BOND_WIDTH'($urandom_range(7))
                                                  : BOND_WIDTH'($urandom_range(255));
        p.start       = start;
        p.last        = last;
        return p;
    endfunction

    // result side: check accepted words, then pick ready for the next edge
    initial
    begin
        verdict_t got;
        int       hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.is_clash        = result_ch.is_clash;
                got.clash_total     = result_ch.clash_total;
                got.unknown_element = result_ch.unknown_element;
                got.final_result    = result_ch.final_result;
                board.check_verdict(got);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = PRESSURE_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        pair_word_t        p;
        logic [DATA_W-1:0] rows [4];
        logic [2:0]        ra;
        logic [2:0]        rb;
        int                dx;
        int                left;
        bit                start;
        bit                last;

        pair_ch.valid               = 1'b0;
        pair_ch.first_element_char  = '0;
        pair_ch.second_element_char = '0;
        pair_ch.first_x             = '0;
        pair_ch.first_y             = '0;
        pair_ch.first_z             = '0;
        pair_ch.second_x            = '0;
        pair_ch.second_y            = '0;
        pair_ch.second_z            = '0;
        pair_ch.bond_separation     = '0;
        pair_ch.start_of_structure  = 1'b0;
        pair_ch.last_pair           = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // every element pair, one unit inside its limit
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ra = board.row_of(ROW_CHARS[CHAR_WIDTH*i +: CHAR_WIDTH]);
                rb = board.row_of(ROW_CHARS[CHAR_WIDTH*j +: CHAR_WIDTH]);
                dx = int'(board.limit_of(ra, rb)) - 1;
                if ((i + j) % 2 == 1)
                    dx = -dx;
                drive_pair(pair_at(ROW_CHARS[CHAR_WIDTH*i +: CHAR_WIDTH],
                                   ROW_CHARS[CHAR_WIDTH*j +: CHAR_WIDTH], dx, 8'd4,
                                   i == 0 && j == 0, 1'b0));
            end
        end
        // exactly at the limit: not closer
        drive_pair(pair_at(CHAR_C, CHAR_C, LIMIT_CC, 8'd255, 1'b0, 1'b0));
        // too few bonds apart
        drive_pair(pair_at(CHAR_C, CHAR_C, 0, BOND_LIMIT, 1'b0, 1'b0));
        drive_pair(pair_at(CHAR_C, CHAR_C, 0, 8'd0, 1'b0, 1'b0));
        // unknown letters, flagged whatever the bonds
        drive_pair(pair_at(8'h00, CHAR_C, 0, 8'd0, 1'b0, 1'b0));
        drive_pair(pair_at(CHAR_C, 8'hFF, 0, 8'd255, 1'b0, 1'b0));
        // far component
        drive_pair(pair_at(CHAR_C, CHAR_C, -(1 << RW), 8'd4, 1'b0, 1'b0));
        // coordinate extremes
        p = pair_at(CHAR_O, CHAR_N, 0, 8'd200, 1'b1, 1'b0);
        p.first_x  = {1'b1, {(CW-1){1'b0}}};
        p.first_y  = {1'b1, {(CW-1){1'b0}}};
        p.first_z  = {1'b1, {(CW-1){1'b0}}};
        p.second_x = {1'b0, {(CW-1){1'b1}}};
        p.second_y = {1'b0, {(CW-1){1'b1}}};
        p.second_z = {1'b0, {(CW-1){1'b1}}};
        drive_pair(p);
        p.first_x  = p.second_x;
        p.first_y  = p.second_y;
        p.first_z  = p.second_z;
        p.start    = 1'b0;
        drive_pair(p);
        p.first_x  = {1'b1, {(CW-1){1'b0}}};
        p.first_y  = {1'b1, {(CW-1){1'b0}}};
        p.first_z  = {1'b1, {(CW-1){1'b0}}};
        p.second_x = p.first_x;
        p.second_y = p.first_y;
        p.second_z = p.first_z;
        p.last     = 1'b1;
        drive_pair(p);

        for (int seg = 0; seg < 6; seg++)
        begin
            pair_ch.valid <= 1'b0;
            wait_drained();
            case (seg)
                0: foreach (rows[r]) rows[r] = '1;
                2: foreach (rows[r]) rows[r] = '0;
                4:
                begin
                    rows[REG_CARBON]   = {RW'(LIMIT_CH), RW'(LIMIT_CN), RW'(LIMIT_CO),
                                          RW'(LIMIT_CC)};
                    rows[REG_OXYGEN]   = DATA_W'({RW'(LIMIT_OH), RW'(LIMIT_ON),
                                                  RW'(LIMIT_OO)});
                    rows[REG_NITROGEN] = DATA_W'({RW'(LIMIT_NH), RW'(LIMIT_NN)});
                    rows[REG_HYDROGEN] = DATA_W'(LIMIT_HH);
                end
                default: foreach (rows[r]) rows[r] = DATA_W'({$urandom(), $urandom()});
            endcase
            write_radius(REG_CARBON, rows[REG_CARBON]);
            write_radius(REG_OXYGEN, rows[REG_OXYGEN]);
            write_radius(REG_NITROGEN, rows[REG_NITROGEN]);
            write_radius(REG_HYDROGEN, rows[REG_HYDROGEN]);
            cfg_we <= 1'b0;

            if (seg < 2)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 67;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long stall on the result side while pairs keep coming
            if (seg == 4)
                hold_request = 1'b1;

            // structures of random length, with a few broken markers
            left = 0;
            repeat (PAIRS_PER_PHASE)
            begin
                start = (left == 0);
                if (left == 0)
                    left = $urandom_range(1, 24);
                last = (left == 1);
                left--;
                if ($urandom_range(99) < 5)
                    start = !start;
                if ($urandom_range(99) < 5)
                    last = !last;
                drive_pair(random_pair(start, last));
            end
        end

        pair_ch.valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        if (board.failures == 0 && board.pending_verdicts.size() == 0)
            $display("atom_pair_clash_counter_top: match");
        else
            $display("atom_pair_clash_counter_top: mismatch");
        $finish;
    end

    initial
    begin
        #200000;
        $display("atom_pair_clash_counter_top: mismatch");
        $finish;
    end

endmodule
